FILE: rtl/trsp_pkg.sv
package trsp_pkg;

  localparam logic [4:0] PH_OPEN     = 5'd0;
  localparam logic [4:0] PH_NAME     = 5'd1;
  localparam logic [4:0] PH_NAME_EXT = 5'd2;
  localparam logic [4:0] PH_NAME_CHR = 5'd3;
  localparam logic [4:0] PH_ATOMS    = 5'd4;
  localparam logic [4:0] PH_KEY      = 5'd5;
  localparam logic [4:0] PH_KEY_EXT  = 5'd6;
  localparam logic [4:0] PH_KEY_CHR  = 5'd7;
  localparam logic [4:0] PH_TYPE     = 5'd8;
  localparam logic [4:0] PH_FIXED    = 5'd9;
  localparam logic [4:0] PH_VSTR     = 5'd10;
  localparam logic [4:0] PH_VSTR_EXT = 5'd11;
  localparam logic [4:0] PH_VSTR_CHR = 5'd12;
  localparam logic [4:0] PH_ACOUNT   = 5'd13;
  localparam logic [4:0] PH_AELEM    = 5'd14;
  localparam logic [4:0] PH_RLEN     = 5'd15;
  localparam logic [4:0] PH_RDATA    = 5'd16;
  localparam logic [4:0] PH_NCOUNT   = 5'd17;
  localparam logic [4:0] PH_CLOSE    = 5'd18;
  localparam logic [4:0] PH_ERROR    = 5'd19;
  localparam logic [4:0] PH_USTR     = 5'd20;
  localparam logic [4:0] PH_USTR_EXT = 5'd21;
  localparam logic [4:0] PH_USTR_CHR = 5'd22;

  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_NO_OPEN   = 3'd1;
  localparam logic [2:0] ERR_NO_CLOSE  = 3'd2;
  localparam logic [2:0] ERR_BAD_TYPE  = 3'd3;
  localparam logic [2:0] ERR_TOO_DEEP  = 3'd4;
  localparam logic [2:0] ERR_TRUNCATED = 3'd5;

  localparam logic [7:0] TY_INT       = 8'd1;
  localparam logic [7:0] TY_FLOAT     = 8'd2;
  localparam logic [7:0] TY_CHAR      = 8'd3;
  localparam logic [7:0] TY_STRING    = 8'd4;
  localparam logic [7:0] TY_BOOL      = 8'd5;
  localparam logic [7:0] TY_RAW       = 8'd6;
  localparam logic [7:0] TY_DOUBLE    = 8'd7;
  localparam logic [7:0] TY_INT_ARRAY = 8'd8;
  localparam logic [7:0] TY_LONG      = 8'd9;
  localparam logic [7:0] TY_UNICODE   = 8'd10;

  localparam logic [7:0] CH_OPEN  = 8'h3C;
  localparam logic [7:0] CH_CLOSE = 8'h3E;
  localparam logic [7:0] CH_ESC   = 8'hFF;
  localparam logic [7:0] CH_SUB   = 8'h5F;

  typedef struct packed {
    logic [4:0]  role;
    logic [63:0] value;
    logic        value_done;
    logic [3:0]  value_type;
    logic [4:0]  depth;
    logic        record_done;
    logic [2:0]  error_code;
  } result_t;

endpackage

FILE: rtl/tagged_record_stream_parser.sv
// result: the result for each accepted byte is captured in the output register
// at the same edge that accepts the byte
// throughput: one byte per cycle while the result side is not stalling, set by the single-pass parse logic
// reset: asynchronous active low; parser waits for an open mark at level zero
// nested count stack has no reset and is written before it is read
module tagged_record_stream_parser import trsp_pkg::*; #(
  parameter int MAX_DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // data_byte
  input  logic        s_axis_tlast,  // last_byte
  input  logic        s_axis_tuser,  // first_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [87:0] m_axis_tdata,  // role, value, value_type, depth, error_code,
                                     // zero fill
  output logic        m_axis_tlast,  // record_done
  output logic        m_axis_tuser   // value_done
);

  logic    step;
  result_t res;
  logic    out_valid_q;
  result_t out_q;

  // output register frees up whenever it is empty or being drained
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign step = s_axis_tvalid && s_axis_tready;

  trsp_core #(.MAX_DEPTH(MAX_DEPTH)) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step),
    .data_byte_i  (s_axis_tdata),
    .first_byte_i (s_axis_tuser),
    .last_byte_i  (s_axis_tlast),
    .res_o        (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      out_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) out_q <= res;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, out_q.error_code, out_q.depth, out_q.value_type,
                          out_q.value, out_q.role};
  assign m_axis_tlast  = out_q.record_done;
  assign m_axis_tuser  = out_q.value_done;

endmodule

FILE: rtl/trsp_core.sv
module trsp_core import trsp_pkg::*; #(
  parameter int MAX_DEPTH = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          step_i,
  input  logic [7:0]    data_byte_i,
  input  logic          first_byte_i,
  input  logic          last_byte_i,
  output result_t       res_o
);

  localparam int SW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int LW = $clog2(MAX_DEPTH + 1);

  logic [4:0]    phase_q, phase_d;
  logic [7:0]    atoms_q, atoms_d;
  logic [LW-1:0] level_q, level_d;
  logic [63:0]   asm_q, asm_d;
  logic [2:0]    bidx_q, bidx_d;
  logic [31:0]   run_q, run_d;
  logic [7:0]    arr_q, arr_d;
  logic [3:0]    ctype_q, ctype_d;
  logic [2:0]    elatch_q, elatch_d;
  logic [7:0]    nest_mem [MAX_DEPTH];

  // nested counts, one write per cycle
  logic          nwr;
  logic [SW-1:0] nwr_addr;
  logic [7:0]    nwr_data;

  always_ff @(posedge clk_i) begin
    if (step_i && nwr) nest_mem[nwr_addr] <= nwr_data;
  end

  // effective state after a possible first-byte restart
  logic [4:0]    ph;
  logic [7:0]    atoms;
  logic [LW-1:0] lvl;
  logic [63:0]   asmv;
  logic [2:0]    bidx;
  logic [31:0]   run;
  logic [7:0]    arr;
  logic [3:0]    ctype;
  logic [2:0]    elat;
  logic [SW-1:0] cur_slot, dn_slot;
  logic [63:0]   taken;
  logic [2:0]    pos;
  logic [2:0]    err;
  logic [4:0]    role;
  logic [63:0]   val;
  logic          done, rdone;
  logic [LW-1:0] dep;
  logic [4:0]    base;
  logic [3:0]    fsize;
  logic [LW-1:0] lvl_dn;
  logic [15:0]   word;

  always_comb begin
    ph    = first_byte_i ? PH_OPEN : phase_q;
    atoms = first_byte_i ? 8'd0 : atoms_q;
    lvl   = first_byte_i ? '0 : level_q;
    asmv  = first_byte_i ? 64'd0 : asm_q;
    bidx  = first_byte_i ? 3'd0 : bidx_q;
    run   = first_byte_i ? 32'd0 : run_q;
    arr   = first_byte_i ? 8'd0 : arr_q;
    ctype = first_byte_i ? 4'd0 : ctype_q;
    elat  = first_byte_i ? ERR_NONE : elatch_q;
    cur_slot = (lvl == '0) ? '0 : SW'(lvl - LW'(1));
    lvl_dn   = (lvl == '0) ? '0 : lvl - LW'(1);
    dn_slot  = (lvl_dn == '0) ? '0 : SW'(lvl_dn - LW'(1));
    pos   = bidx;
    taken = asmv | (64'(data_byte_i) << {pos, 3'b000});
    word  = taken[15:0];
    fsize = ({4'd0, ctype} == TY_CHAR || {4'd0, ctype} == TY_BOOL) ? 4'd1 :
            ({4'd0, ctype} == TY_DOUBLE || {4'd0, ctype} == TY_LONG) ? 4'd8 : 4'd4;
    base  = PH_OPEN;

    phase_d = ph; atoms_d = atoms; level_d = lvl; asm_d = asmv; bidx_d = bidx;
    run_d = run; arr_d = arr; ctype_d = ctype; elatch_d = elat;
    nwr = 1'b0; nwr_addr = cur_slot; nwr_data = 8'd0;
    role = PH_ERROR; err = ERR_NONE; val = 64'd0; done = 1'b0; rdone = 1'b0;
    dep = lvl;

    case (ph)
      PH_OPEN: begin
        if (data_byte_i != CH_OPEN) begin
          err = ERR_NO_OPEN;
        end else if (32'(lvl) >= MAX_DEPTH) begin
          err = ERR_TOO_DEEP;
        end else begin
          if (lvl != '0) begin
            nwr = 1'b1; nwr_data = nest_mem[cur_slot] - 8'd1;
          end
          level_d = lvl + LW'(1);
          atoms_d = 8'd0;
          dep = lvl + LW'(1);
          role = PH_OPEN; val = 64'(data_byte_i); done = 1'b1;
          phase_d = PH_NAME;
        end
      end
      PH_NAME, PH_KEY, PH_VSTR, PH_USTR: begin
        base = ph;
        role = (ph == PH_USTR) ? PH_VSTR : ph;
        if (ph == PH_KEY && atoms != 8'd0) atoms_d = atoms - 8'd1;
        asm_d = 64'd0; bidx_d = 3'd0;
        if (data_byte_i == CH_ESC) begin
          val = 64'd255;
          phase_d = base + 5'd1;
        end else begin
          run_d = 32'(data_byte_i); val = 64'(data_byte_i); done = 1'b1;
          if (data_byte_i == 8'd0) begin
            if (base == PH_NAME) phase_d = PH_ATOMS;
            else if (base == PH_KEY) phase_d = PH_TYPE;
            else phase_d = (atoms_d == 8'd0) ? PH_NCOUNT : PH_KEY;
          end else begin
            phase_d = base + 5'd2;
          end
        end
      end
      PH_NAME_EXT, PH_KEY_EXT, PH_VSTR_EXT, PH_USTR_EXT: begin
        base = ph - 5'd1;
        role = (base == PH_USTR) ? PH_VSTR_EXT : ph;
        asm_d = taken; bidx_d = pos + 3'd1; val = taken;
        if (pos == 3'd3) begin
          done = 1'b1;
          run_d = taken[31:0];
          asm_d = 64'd0; bidx_d = 3'd0;
          if (taken[31:0] == 32'd0) begin
            if (base == PH_NAME) phase_d = PH_ATOMS;
            else if (base == PH_KEY) phase_d = PH_TYPE;
            else phase_d = (atoms == 8'd0) ? PH_NCOUNT : PH_KEY;
          end else begin
            phase_d = base + 5'd2;
          end
        end
      end
      PH_NAME_CHR, PH_KEY_CHR, PH_VSTR_CHR: begin
        role = ph;
        val = (data_byte_i != 8'd0) ? 64'(data_byte_i) : 64'(CH_SUB);
        done = 1'b1;
        run_d = run - 32'd1;
        if (run == 32'd1) begin
          if (ph == PH_NAME_CHR) phase_d = PH_ATOMS;
          else if (ph == PH_KEY_CHR) phase_d = PH_TYPE;
          else phase_d = (atoms == 8'd0) ? PH_NCOUNT : PH_KEY;
        end
      end
      PH_USTR_CHR: begin
        role = PH_VSTR_CHR;
        asm_d = taken; bidx_d = pos + 3'd1; val = taken;
        if (pos == 3'd1) begin
          val = (word != 16'd0) ? 64'(word) : 64'(CH_SUB);
          done = 1'b1;
          asm_d = 64'd0; bidx_d = 3'd0;
          run_d = run - 32'd1;
          if (run == 32'd1) phase_d = (atoms == 8'd0) ? PH_NCOUNT : PH_KEY;
        end
      end
      PH_ATOMS: begin
        role = PH_ATOMS; val = 64'(data_byte_i); done = 1'b1;
        atoms_d = data_byte_i;
        phase_d = (data_byte_i == 8'd0) ? PH_NCOUNT : PH_KEY;
      end
      PH_TYPE: begin
        if (data_byte_i < TY_INT || data_byte_i > TY_UNICODE) begin
          err = ERR_BAD_TYPE;
        end else begin
          role = PH_TYPE; val = 64'(data_byte_i); done = 1'b1;
          ctype_d = data_byte_i[3:0];
          asm_d = 64'd0; bidx_d = 3'd0;
          case (data_byte_i)
            TY_STRING:    phase_d = PH_VSTR;
            TY_RAW:       phase_d = PH_RLEN;
            TY_INT_ARRAY: phase_d = PH_ACOUNT;
            TY_UNICODE:   phase_d = PH_USTR;
            default:      phase_d = PH_FIXED;
          endcase
        end
      end
      PH_FIXED: begin
        role = PH_FIXED;
        asm_d = taken; bidx_d = pos + 3'd1; val = taken;
        if ({1'b0, pos} + 4'd1 >= fsize) begin
          done = 1'b1; asm_d = 64'd0; bidx_d = 3'd0;
          phase_d = (atoms == 8'd0) ? PH_NCOUNT : PH_KEY;
        end
      end
      PH_ACOUNT: begin
        role = PH_ACOUNT; val = 64'(data_byte_i); done = 1'b1;
        arr_d = data_byte_i; asm_d = 64'd0; bidx_d = 3'd0;
        if (data_byte_i == 8'd0) phase_d = (atoms == 8'd0) ? PH_NCOUNT : PH_KEY;
        else phase_d = PH_AELEM;
      end
      PH_AELEM: begin
        role = PH_AELEM;
        asm_d = taken; bidx_d = pos + 3'd1; val = taken;
        if (pos == 3'd3) begin
          done = 1'b1; asm_d = 64'd0; bidx_d = 3'd0;
          arr_d = arr - 8'd1;
          if (arr == 8'd1) phase_d = (atoms == 8'd0) ? PH_NCOUNT : PH_KEY;
        end
      end
      PH_RLEN: begin
        role = PH_RLEN;
        asm_d = taken; bidx_d = pos + 3'd1; val = taken;
        if (pos == 3'd3) begin
          done = 1'b1; run_d = taken[31:0]; asm_d = 64'd0; bidx_d = 3'd0;
          if (taken[31:0] == 32'd0) phase_d = (atoms == 8'd0) ? PH_NCOUNT : PH_KEY;
          else phase_d = PH_RDATA;
        end
      end
      PH_RDATA: begin
        role = PH_RDATA; val = 64'(data_byte_i); done = 1'b1;
        run_d = run - 32'd1;
        if (run == 32'd1) phase_d = (atoms == 8'd0) ? PH_NCOUNT : PH_KEY;
      end
      PH_NCOUNT: begin
        role = PH_NCOUNT; val = 64'(data_byte_i); done = 1'b1;
        nwr = 1'b1; nwr_data = data_byte_i;
        phase_d = (data_byte_i != 8'd0) ? PH_OPEN : PH_CLOSE;
      end
      PH_CLOSE: begin
        if (data_byte_i != CH_CLOSE) begin
          err = ERR_NO_CLOSE;
        end else begin
          role = PH_CLOSE; val = 64'(data_byte_i); done = 1'b1;
          level_d = lvl_dn;
          if (lvl_dn == '0) begin
            rdone = 1'b1; phase_d = PH_OPEN;
          end else begin
            phase_d = (nest_mem[dn_slot] != 8'd0) ? PH_OPEN : PH_CLOSE;
          end
        end
      end
      default: err = elat;
    endcase

    if (err != ERR_NONE) begin
      role = PH_ERROR; val = 64'd0; done = 1'b0; rdone = 1'b0;
      dep = lvl; phase_d = PH_ERROR; elatch_d = err;
      nwr = 1'b0;
      phase_d = PH_ERROR;
      level_d = lvl; atoms_d = atoms; asm_d = asmv; bidx_d = bidx;
      run_d = run; arr_d = arr; ctype_d = ctype;
    end else if (last_byte_i && !(phase_d == PH_OPEN && level_d == '0)) begin
      err = ERR_TRUNCATED; phase_d = PH_ERROR; elatch_d = ERR_TRUNCATED;
    end

    res_o.role        = role;
    res_o.value       = val;
    res_o.value_done  = done;
    res_o.value_type  = (role >= PH_TYPE && role <= PH_RDATA) ? ctype_d : 4'd0;
    res_o.depth       = 5'(dep);
    res_o.record_done = rdone;
    res_o.error_code  = err;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_OPEN; atoms_q <= '0; level_q <= '0; asm_q <= '0;
      bidx_q <= '0; run_q <= '0; arr_q <= '0; ctype_q <= '0; elatch_q <= ERR_NONE;
    end else if (step_i) begin
      phase_q <= phase_d; atoms_q <= atoms_d; level_q <= level_d; asm_q <= asm_d;
      bidx_q <= bidx_d; run_q <= run_d; arr_q <= arr_d; ctype_q <= ctype_d;
      elatch_q <= elatch_d;
    end
  end

endmodule

FILE: bench/tb.sv
module tb;
  import trsp_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;  // data_byte
  logic        s_axis_tlast = 1'b0;  // last_byte
  logic        s_axis_tuser = 1'b0;  // first_byte
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [87:0] m_axis_tdata;  // role, value, value_type, depth, error_code
  logic        m_axis_tlast;  // record_done
  logic        m_axis_tuser;  // value_done

  tagged_record_stream_parser u_dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // parser shadow state
  logic [4:0]  sh_phase;
  logic [7:0]  sh_atoms;
  logic [7:0]  sh_nested [16];
  logic [4:0]  sh_level;
  logic [63:0] sh_asm;
  logic [2:0]  sh_idx;
  logic [31:0] sh_run;
  logic [7:0]  sh_array;
  logic [3:0]  sh_type;
  logic [2:0]  sh_err;

  result_t     labels_due [$];
  logic [7:0]  rec_bytes [$];
  int          failures = 0;
  int          bytes_sent = 0;
  int          cycles = 0;
  bit          no_idle = 0;
  bit          hold_req = 0;

  function automatic void add_byte(input logic [7:0] b);
    rec_bytes = {rec_bytes, b};
  endfunction

  function automatic void atom_done();
    sh_phase = (sh_atoms == 0) ? PH_NCOUNT : PH_KEY;
  endfunction

  function automatic void string_done(input logic [4:0] base);
    if (base == PH_NAME) sh_phase = PH_ATOMS;
    else if (base == PH_KEY) sh_phase = PH_TYPE;
    else atom_done();
  endfunction

  function automatic int take_byte(input logic [7:0] b);
    int pos;
    pos = sh_idx;
    sh_asm |= 64'(b) << (8 * pos);
    sh_idx = sh_idx + 3'd1;
    return pos;
  endfunction

  function automatic result_t label_byte(input logic [7:0] b, input bit first, input bit last);
    result_t r;
    logic [4:0] role, dep, base;
    logic [2:0] err;
    logic [63:0] val;
    bit done, rdone;
    int pos, sl, fsz;
    role = PH_ERROR; err = ERR_NONE; val = '0; done = 0; rdone = 0;
    if (first) begin
      sh_phase = PH_OPEN; sh_atoms = 0; sh_level = 0; sh_asm = 0; sh_idx = 0;
      sh_run = 0; sh_array = 0; sh_type = 0; sh_err = ERR_NONE;
      foreach (sh_nested[i]) sh_nested[i] = 0;
    end
    dep = sh_level;
    sl = (sh_level == 0) ? 0 : sh_level - 1;
    case (sh_phase)
      PH_OPEN: begin
        if (b != CH_OPEN) err = ERR_NO_OPEN;
        else if (sh_level >= 16) err = ERR_TOO_DEEP;
        else begin
          if (sh_level > 0) sh_nested[sl] = sh_nested[sl] - 8'd1;
          sh_level = sh_level + 5'd1;
          sh_atoms = 0;
          dep = sh_level;
          role = PH_OPEN; val = b; done = 1;
          sh_phase = PH_NAME;
        end
      end
      PH_NAME, PH_KEY, PH_VSTR, PH_USTR: begin
        base = sh_phase;
        role = (sh_phase == PH_USTR) ? PH_VSTR : sh_phase;
        if (sh_phase == PH_KEY && sh_atoms > 0) sh_atoms = sh_atoms - 8'd1;
        sh_asm = 0; sh_idx = 0;
        if (b == CH_ESC) begin
          val = 64'd255;
          sh_phase = base + 5'd1;
        end else begin
          sh_run = b; val = b; done = 1;
          if (b == 0) string_done(base); else sh_phase = base + 5'd2;
        end
      end
      PH_NAME + 5'd1, PH_KEY + 5'd1, PH_VSTR + 5'd1, PH_USTR + 5'd1: begin
        base = sh_phase - 5'd1;
        role = (base == PH_USTR) ? PH_VSTR + 5'd1 : sh_phase;
        pos = take_byte(b);
        val = sh_asm;
        if (pos == 3) begin
          done = 1;
          sh_run = sh_asm[31:0];
          sh_asm = 0; sh_idx = 0;
          if (sh_run == 0) string_done(base); else sh_phase = base + 5'd2;
        end
      end
      PH_NAME + 5'd2, PH_KEY + 5'd2, PH_VSTR + 5'd2: begin
        role = sh_phase;
        val = (b != 0) ? 64'(b) : 64'(CH_SUB); done = 1;
        sh_run = sh_run - 1;
        if (sh_run == 0) string_done(sh_phase - 5'd2);
      end
      PH_USTR + 5'd2: begin
        // unicode strings count 16-bit words
        role = PH_VSTR + 5'd2;
        pos = take_byte(b);
        val = sh_asm;
        if (pos == 1) begin
          val = (sh_asm[15:0] != 0) ? 64'(sh_asm[15:0]) : 64'(CH_SUB); done = 1;
          sh_asm = 0; sh_idx = 0;
          sh_run = sh_run - 1;
          if (sh_run == 0) atom_done();
        end
      end
      PH_ATOMS: begin
        role = PH_ATOMS; val = b; done = 1;
        sh_atoms = b;
        atom_done();
      end
      PH_TYPE: begin
        if (b < TY_INT || b > TY_UNICODE) err = ERR_BAD_TYPE;
        else begin
          role = PH_TYPE; val = b; done = 1;
          sh_type = b[3:0];
          sh_asm = 0; sh_idx = 0;
          case (b)
            TY_STRING: sh_phase = PH_VSTR;
            TY_RAW: sh_phase = PH_RLEN;
            TY_INT_ARRAY: sh_phase = PH_ACOUNT;
            TY_UNICODE: sh_phase = PH_USTR;
            default: sh_phase = PH_FIXED;
          endcase
        end
      end
      PH_FIXED: begin
        role = PH_FIXED;
        pos = take_byte(b);
        val = sh_asm;
        fsz = ({4'd0, sh_type} == TY_CHAR || {4'd0, sh_type} == TY_BOOL) ? 1 :
              ({4'd0, sh_type} == TY_DOUBLE || {4'd0, sh_type} == TY_LONG) ? 8 : 4;
        if (pos + 1 >= fsz) begin
          done = 1; sh_asm = 0; sh_idx = 0; atom_done();
        end
      end
      PH_ACOUNT: begin
        role = PH_ACOUNT; val = b; done = 1;
        sh_array = b;
        sh_asm = 0; sh_idx = 0;
        if (b == 0) atom_done(); else sh_phase = PH_AELEM;
      end
      PH_AELEM: begin
        role = PH_AELEM;
        pos = take_byte(b);
        val = sh_asm;
        if (pos == 3) begin
          done = 1; sh_asm = 0; sh_idx = 0;
          sh_array = sh_array - 8'd1;
          if (sh_array == 0) atom_done();
        end
      end
      PH_RLEN: begin
        role = PH_RLEN;
        pos = take_byte(b);
        val = sh_asm;
        if (pos == 3) begin
          done = 1;
          sh_run = sh_asm[31:0];
          sh_asm = 0; sh_idx = 0;
          if (sh_run == 0) atom_done(); else sh_phase = PH_RDATA;
        end
      end
      PH_RDATA: begin
        role = PH_RDATA; val = b; done = 1;
        sh_run = sh_run - 1;
        if (sh_run == 0) atom_done();
      end
      PH_NCOUNT: begin
        role = PH_NCOUNT; val = b; done = 1;
        sh_nested[sl] = b;
        sh_phase = (b != 0) ? PH_OPEN : PH_CLOSE;
      end
      PH_CLOSE: begin
        if (b != CH_CLOSE) err = ERR_NO_CLOSE;
        else begin
          role = PH_CLOSE; val = b; done = 1;
          if (sh_level > 0) sh_level = sh_level - 5'd1;
          sl = (sh_level == 0) ? 0 : sh_level - 1;
          if (sh_level == 0) begin
            rdone = 1; sh_phase = PH_OPEN;
          end else begin
            sh_phase = (sh_nested[sl] != 0) ? PH_OPEN : PH_CLOSE;
          end
        end
      end
      default: err = sh_err;
    endcase
    if (err != ERR_NONE) begin
      role = PH_ERROR; val = 0; done = 0; rdone = 0;
      dep = sh_level;
      sh_phase = PH_ERROR;
      sh_err = err;
    end else if (last && !(sh_phase == PH_OPEN && sh_level == 0)) begin
      err = ERR_TRUNCATED;
      sh_phase = PH_ERROR;
      sh_err = ERR_TRUNCATED;
    end
    r.role = role;
    r.value = val;
    r.value_done = done;
    r.value_type = (role >= PH_TYPE && role <= PH_RDATA) ? sh_type : 4'd0;
    r.depth = dep;
    r.record_done = rdone;
    r.error_code = err;
    return r;
  endfunction

  // record builders, bytes collect in rec_bytes
  function automatic void push_len32(input int n);
    for (int i = 0; i < 4; i++) add_byte(8'(n >> (8 * i)));
  endfunction

  function automatic void push_len(input int n);
    if ($urandom_range(0, 5) == 0 || n >= 255) begin
      add_byte(CH_ESC);
      push_len32(n);
    end else begin
      add_byte(8'(n));
    end
  endfunction

  function automatic logic [7:0] rand_char();
    return ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom);
  endfunction

  function automatic void build_string(input int words);
    int n;
    n = $urandom_range(0, 4);
    push_len(n);
    for (int i = 0; i < n * words; i++) add_byte(rand_char());
  endfunction

  function automatic void build_atom(input logic [7:0] t);
    int n;
    build_string(1);
    add_byte(t);
    case (t)
      TY_STRING: build_string(1);
      TY_UNICODE: build_string(2);
      TY_RAW: begin
        n = $urandom_range(0, 5);
        push_len32(n);
        for (int i = 0; i < n; i++) add_byte(8'($urandom));
      end
      TY_INT_ARRAY: begin
        n = $urandom_range(0, 3);
        add_byte(8'(n));
        for (int i = 0; i < 4 * n; i++) add_byte(8'($urandom));
      end
      TY_CHAR, TY_BOOL: add_byte(8'($urandom));
      TY_DOUBLE, TY_LONG: for (int i = 0; i < 8; i++) add_byte(8'($urandom));
      default: for (int i = 0; i < 4; i++) add_byte(8'($urandom));
    endcase
  endfunction

  function automatic void build_tag(input int lvl, input int max_lvl);
    int n;
    add_byte(CH_OPEN);
    build_string(1);
    n = $urandom_range(0, 3);
    add_byte(8'(n));
    for (int i = 0; i < n; i++) build_atom(8'($urandom_range(1, 10)));
    n = (lvl < max_lvl) ? $urandom_range(0, 2) : 0;
    add_byte(8'(n));
    for (int i = 0; i < n; i++) build_tag(lvl + 1, max_lvl);
    add_byte(CH_CLOSE);
  endfunction

  // one byte through the input handshake
  task automatic send_byte(input logic [7:0] b, input bit first, input bit last);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= first;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    labels_due = {labels_due, label_byte(b, first, last)};
    bytes_sent++;
  endtask

  // send rec_bytes, cut short with last_byte at index cut when cut >= 0
  task automatic send_record(input bit first, input int cut);
    int n;
    n = (cut >= 0 && cut < rec_bytes.size()) ? cut + 1 : rec_bytes.size();
    for (int i = 0; i < n; i++) send_byte(rec_bytes[i], first && i == 0, i == n - 1);
    rec_bytes.delete();
  endtask

  task automatic test_minimal_records();
    rec_bytes = '{CH_OPEN, 8'd0, 8'd0, 8'd0, CH_CLOSE};
    send_record(1, -1);
    // a second record without a new buffer start
    rec_bytes = '{CH_OPEN, CH_ESC, 8'd1, 8'd0, 8'd0, 8'd0, 8'h00, 8'd0, 8'd0, CH_CLOSE};
    send_record(0, -1);
  endtask

  task automatic test_all_types();
    add_byte(CH_OPEN);
    build_string(1);
    add_byte(8'd10);
    for (int t = 1; t <= 10; t++) build_atom(8'(t));
    add_byte(8'd0);
    add_byte(CH_CLOSE);
    send_record(1, -1);
    // extreme field values
    rec_bytes = '{CH_OPEN, 8'd1, 8'hFF, 8'd1, 8'd0, TY_LONG,
                  8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'd0, CH_CLOSE};
    send_record(1, -1);
  endtask

  task automatic test_errors();
    rec_bytes = '{8'h00, CH_OPEN, 8'hFF};             // missing open, then sticky
    send_record(1, -1);
    rec_bytes = '{CH_OPEN, 8'd0, 8'd0, 8'd0, 8'h00};  // missing close
    send_record(1, -1);
    rec_bytes = '{CH_OPEN, 8'd0, 8'd1, 8'd0, 8'd0};   // type code zero
    send_record(1, -1);
    rec_bytes = '{CH_OPEN, 8'd0, 8'd1, 8'd0, 8'd11};  // type code above range
    send_record(1, -1);
    // one level too deep
    for (int i = 0; i < 16; i++) rec_bytes = {rec_bytes, CH_OPEN, 8'd0, 8'd0, 8'd1};
    add_byte(CH_OPEN);
    send_record(1, -1);
    // exactly the deepest legal nesting
    for (int i = 0; i < 16; i++) rec_bytes = {rec_bytes, CH_OPEN, 8'd0, 8'd0, 8'(i < 15)};
    for (int i = 0; i < 16; i++) add_byte(CH_CLOSE);
    send_record(1, -1);
    // truncated buffer
    build_tag(0, 2);
    send_record(1, $urandom_range(0, 6));
  endtask

  task automatic test_backpressure();
    no_idle = 1;
    hold_req = 1;
    build_tag(0, 3);
    send_record(1, -1);
    no_idle = 0;
  endtask

  task automatic test_random_records();
    int kind, cut;
    while (bytes_sent < 950) begin
      kind = $urandom_range(0, 19);
      no_idle = (kind == 0);
      if (kind == 1) begin
        // noise bytes
        repeat ($urandom_range(1, 8)) send_byte(8'($urandom), $urandom_range(0, 1),
                                                $urandom_range(0, 1));
      end else begin
        build_tag(0, $urandom_range(0, 3));
        cut = -1;
        if (kind == 2) cut = $urandom_range(0, rec_bytes.size() - 1);
        if (kind == 3) rec_bytes[$urandom_range(0, rec_bytes.size() - 1)] = 8'($urandom);
        send_record(kind != 4, cut);
      end
    end
    no_idle = 0;
  endtask

  // result side: random stalls, one long hold-off on request
  initial begin
    int stall;
    forever begin
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (200) @(posedge clk_i);
        hold_req = 0;
      end else begin
        stall = no_idle ? 0 : $urandom_range(0, 13);
        if (stall > 0) begin
          m_axis_tready <= 1'b0;
          repeat (stall) @(posedge clk_i);
        end
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  always @(posedge clk_i) begin
    result_t exp;
    if (m_axis_tvalid && m_axis_tready) begin
      if (labels_due.size() == 0) begin
        $error("result with no byte outstanding");
        failures++;
      end else begin
        exp = labels_due.pop_front();
        if (m_axis_tdata[4:0] !== exp.role) begin
          $error("role exp %0d got %0d", exp.role, m_axis_tdata[4:0]); failures++;
        end
        if (m_axis_tdata[68:5] !== exp.value) begin
          $error("value exp %0h got %0h", exp.value, m_axis_tdata[68:5]); failures++;
        end
        if (m_axis_tdata[72:69] !== exp.value_type) begin
          $error("value_type exp %0d got %0d", exp.value_type, m_axis_tdata[72:69]);
          failures++;
        end
        if (m_axis_tdata[77:73] !== exp.depth) begin
          $error("depth exp %0d got %0d", exp.depth, m_axis_tdata[77:73]); failures++;
        end
        if (m_axis_tdata[80:78] !== exp.error_code) begin
          $error("error_code exp %0d got %0d", exp.error_code, m_axis_tdata[80:78]);
          failures++;
        end
        if (m_axis_tuser !== exp.value_done) begin
          $error("value_done exp %0d got %0d", exp.value_done, m_axis_tuser); failures++;
        end
        if (m_axis_tlast !== exp.record_done) begin
          $error("record_done exp %0d got %0d", exp.record_done, m_axis_tlast); failures++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_minimal_records();
    test_all_types();
    test_errors();
    test_backpressure();
    test_random_records();
    s_axis_tvalid <= 1'b0;
    while (labels_due.size() != 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/trsp_pkg.sv
rtl/trsp_core.sv
rtl/tagged_record_stream_parser.sv
bench/tb.sv
